@@ design/assert_macros.svh @@
// Assertion macros used by the maze carver RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define AST_IMPL(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition must never be seen outside reset.
`define AST_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

@@ design/rdmc_pkg.sv @@
// Types, constants and helpers of the maze carver.
package rdmc_pkg;

  // Store geometry
  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W     = $clog2(STORE_SIZE);
  localparam int X_W        = $clog2(MAX_WIDTH);
  localparam int Y_W        = $clog2(MAX_HEIGHT);

  // Field widths
  localparam int COORD_W   = 6;
  localparam int REQ_W     = 2;
  localparam int DIR_W     = 2;
  localparam int NUM_DIRS  = 4;
  localparam int CELL_W    = 8;
  localparam int CFG_IDX_W = 1;

  // Cell layout: [3:0] unexplored directions, [4] open, [6:5] parent direction, [7] linked
  localparam int OPEN_IDX   = 4;
  localparam int PDIR_SHIFT = 5;
  localparam int LINK_IDX   = 7;
  localparam logic [CELL_W-1:0] CELL_NODE = 8'h1F;
  localparam logic [CELL_W-1:0] CELL_PASS = 8'h10;
  localparam logic [CELL_W-1:0] CELL_LINK = 8'h80;
  localparam logic [CELL_W-1:0] CELL_WALL = 8'h00;

  localparam logic [COORD_W-1:0] START_POS = 6'd1;
  localparam logic [COORD_W-1:0] MIN_SIDE  = 6'd3;
  localparam logic [COORD_W-1:0] SIZE_RST  = 6'd3;

  typedef enum logic [REQ_W-1:0] {
    REQ_START = 2'd0,
    REQ_DRAW  = 2'd1,
    REQ_READ  = 2'd2
  } req_code_t;

  typedef enum logic [DIR_W-1:0] {
    DIR_RIGHT = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_UP    = 2'd3
  } dir_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAZE_WIDTH  = 1'd0,
    REG_MAZE_HEIGHT = 1'd1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_HERE_EVAL,
    ST_TGT_ISSUE,
    ST_TGT_EVAL,
    ST_MID_WR,
    ST_BT_ISSUE,
    ST_BT_EVAL,
    ST_READ_EVAL,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic               cell_open;
    logic               gen_done;
    logic               carved;
    logic [COORD_W-1:0] walk_x;
    logic [COORD_W-1:0] walk_y;
    logic               bad_size;
  } rsp_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [CELL_W-1:0] wdata;
  } mem_req_t;

  // Row-major cell address
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [COORD_W-1:0] x,
                                                  input logic [COORD_W-1:0] y);
    return ADDR_W'((int'(y) * MAX_WIDTH + int'(x)) % STORE_SIZE);
  endfunction

endpackage

@@ design/rdmc_if.sv @@
// Request, response and configuration channel interfaces.
interface rdmc_req_if;
  import rdmc_pkg::*;
  logic               valid;
  logic               ready;
  logic [REQ_W-1:0]   req_type;
  logic [DIR_W-1:0]   rand_dir;
  logic [COORD_W-1:0] read_x;
  logic [COORD_W-1:0] read_y;
  modport source (output valid, req_type, rand_dir, read_x, read_y, input ready);
  modport sink (input valid, req_type, rand_dir, read_x, read_y, output ready);
endinterface

interface rdmc_rsp_if;
  import rdmc_pkg::*;
  logic               valid;
  logic               ready;
  logic               cell_open;
  logic               gen_done;
  logic               carved;
  logic [COORD_W-1:0] walk_x;
  logic [COORD_W-1:0] walk_y;
  logic               bad_size;
  modport source (output valid, cell_open, gen_done, carved, walk_x, walk_y, bad_size,
                  input ready);
  modport sink (input valid, cell_open, gen_done, carved, walk_x, walk_y, bad_size,
                output ready);
endinterface

interface rdmc_cfg_if;
  import rdmc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [COORD_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ design/rdmc_ram.sv @@
// Generic single-port synchronous RAM with registered read.
module rdmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ design/rdmc_ctrl.sv @@
// Sequencer: decodes requests and runs read-modify-write passes over the cell store.
`include "assert_macros.svh"

module rdmc_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  rdmc_req_if.sink                       req,
  rdmc_cfg_if.sink                       cfg,
  output rdmc_pkg::rsp_t                 res,
  output logic                           res_valid,
  input  logic                           res_take,
  output rdmc_pkg::mem_req_t             mem_req,
  input  logic [rdmc_pkg::CELL_W-1:0]    mem_rdata
);
  import rdmc_pkg::*;

  state_t state, state_next;
  logic [COORD_W-1:0] walk_col, walk_col_next, walk_row, walk_row_next;
  logic finished, finished_next;
  logic store_valid, store_valid_next;
  logic [COORD_W-1:0] grid_w, grid_w_next, grid_h, grid_h_next;
  logic [COORD_W-1:0] maze_width, maze_height;
  logic [DIR_W-1:0] dir, dir_next;
  logic [COORD_W-1:0] tgt_x, tgt_x_next, tgt_y, tgt_y_next;
  logic [X_W-1:0] sweep_x, sweep_x_next;
  logic [Y_W-1:0] sweep_y, sweep_y_next;
  logic res_open, res_open_next, res_carved, res_carved_next, res_bad, res_bad_next;
  logic [COORD_W-1:0] mid_x, mid_y;
  logic sweep_last;
  logic [CELL_W-1:0] sweep_val;

  // Wall between the current node and the target
  assign mid_x = COORD_W'(({1'b0, walk_col} + {1'b0, tgt_x}) >> 1);
  assign mid_y = COORD_W'(({1'b0, walk_row} + {1'b0, tgt_y}) >> 1);

  assign sweep_last = (sweep_x == X_W'(MAX_WIDTH - 1)) && (sweep_y == Y_W'(MAX_HEIGHT - 1));

  // Initial contents of the swept cell: node, start node, or wall
  always_comb begin
    sweep_val = CELL_WALL;
    if ((int'(sweep_x) < int'(grid_w)) && (int'(sweep_y) < int'(grid_h)) &&
        sweep_x[0] && sweep_y[0]) begin
      sweep_val = CELL_NODE;
      if ((int'(sweep_x) == int'(START_POS)) && (int'(sweep_y) == int'(START_POS)) &&
          !finished) begin
        sweep_val = CELL_NODE | CELL_LINK;
      end
    end
  end

  assign req.ready = (state == ST_IDLE);
  assign cfg.ready = 1'b1;
  assign res_valid = (state == ST_RESULT);

  assign res.cell_open = res_open;
  assign res.gen_done  = finished;
  assign res.carved    = res_carved;
  assign res.walk_x    = walk_col;
  assign res.walk_y    = walk_row;
  assign res.bad_size  = res_bad;

  // Next state, memory access and register updates
  always_comb begin
    logic [NUM_DIRS-1:0] dir_bits;
    logic                ok;
    logic [COORD_W:0]    sum;
    logic [COORD_W-1:0]  bx, by;

    state_next       = state;
    walk_col_next    = walk_col;
    walk_row_next    = walk_row;
    finished_next    = finished;
    store_valid_next = store_valid;
    grid_w_next      = grid_w;
    grid_h_next      = grid_h;
    dir_next         = dir;
    tgt_x_next       = tgt_x;
    tgt_y_next       = tgt_y;
    sweep_x_next     = sweep_x;
    sweep_y_next     = sweep_y;
    res_open_next    = res_open;
    res_carved_next  = res_carved;
    res_bad_next     = res_bad;
    mem_req          = '0;
    dir_bits         = mem_rdata[NUM_DIRS-1:0];
    ok               = 1'b0;
    sum              = '0;
    bx               = walk_col;
    by               = walk_row;

    unique case (state)
      ST_IDLE: begin
        if (req.valid) begin
          res_open_next   = 1'b0;
          res_carved_next = 1'b0;
          res_bad_next    = 1'b0;
          dir_next        = req.rand_dir;
          unique case (req.req_type)
            REQ_START: begin
              if (!maze_width[0] || !maze_height[0] ||
                  (int'(maze_width) > MAX_WIDTH) || (int'(maze_height) > MAX_HEIGHT)) begin
                res_bad_next = 1'b1;
                state_next   = ST_RESULT;
              end else begin
                grid_w_next      = maze_width;
                grid_h_next      = maze_height;
                walk_col_next    = START_POS;
                walk_row_next    = START_POS;
                finished_next    = !((maze_width >= MIN_SIDE) && (maze_height >= MIN_SIDE));
                store_valid_next = 1'b1;
                sweep_x_next     = '0;
                sweep_y_next     = '0;
                state_next       = ST_SWEEP;
              end
            end
            REQ_DRAW: begin
              if (finished) begin
                state_next = ST_RESULT;
              end else begin
                mem_req.addr = cell_addr(walk_col, walk_row);
                state_next   = ST_HERE_EVAL;
              end
            end
            REQ_READ: begin
              if (store_valid && (req.read_x < grid_w) && (req.read_y < grid_h)) begin
                mem_req.addr = cell_addr(req.read_x, req.read_y);
                state_next   = ST_READ_EVAL;
              end else begin
                state_next = ST_RESULT;
              end
            end
            default: state_next = ST_RESULT;
          endcase
        end
      end

      // One cell per cycle over the whole store
      ST_SWEEP: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = ADDR_W'((int'(sweep_y) * MAX_WIDTH + int'(sweep_x)) % STORE_SIZE);
        mem_req.wdata = sweep_val;
        if (sweep_x == X_W'(MAX_WIDTH - 1)) begin
          sweep_x_next = '0;
          sweep_y_next = sweep_y + Y_W'(1);
        end else begin
          sweep_x_next = sweep_x + X_W'(1);
        end
        if (sweep_last) begin
          state_next = ST_RESULT;
        end
      end

      // Clear the drawn direction if unexplored and pick the target node, else go to backtrack
      ST_HERE_EVAL: begin
        state_next = ST_BT_ISSUE;
        if (dir_bits[dir]) begin
          mem_req.we    = 1'b1;
          mem_req.addr  = cell_addr(walk_col, walk_row);
          mem_req.wdata = mem_rdata & ~(CELL_W'(1) << dir);
          unique case (dir)
            DIR_RIGHT: begin
              sum = {1'b0, walk_col} + (COORD_W + 1)'(2);
              ok  = sum < {1'b0, grid_w};
              bx  = sum[COORD_W-1:0];
            end
            DIR_DOWN: begin
              sum = {1'b0, walk_row} + (COORD_W + 1)'(2);
              ok  = sum < {1'b0, grid_h};
              by  = sum[COORD_W-1:0];
            end
            DIR_LEFT: begin
              ok = walk_col >= COORD_W'(2);
              bx = walk_col - COORD_W'(2);
            end
            default: begin
              ok = walk_row >= COORD_W'(2);
              by = walk_row - COORD_W'(2);
            end
          endcase
          if (ok) begin
            tgt_x_next = bx;
            tgt_y_next = by;
            state_next = ST_TGT_ISSUE;
          end
        end
      end

      ST_TGT_ISSUE: begin
        mem_req.addr = cell_addr(tgt_x, tgt_y);
        state_next   = ST_TGT_EVAL;
      end

      // Link an open, unlinked target and record the parent direction, else go to backtrack
      ST_TGT_EVAL: begin
        if (mem_rdata[OPEN_IDX] && !mem_rdata[LINK_IDX]) begin
          mem_req.we    = 1'b1;
          mem_req.addr  = cell_addr(tgt_x, tgt_y);
          mem_req.wdata = mem_rdata | CELL_LINK | (CELL_W'(dir) << PDIR_SHIFT);
          state_next    = ST_MID_WR;
        end else begin
          state_next = ST_BT_ISSUE;
        end
      end

      // Walls only ever hold the open bit, so a plain write is the full update
      ST_MID_WR: begin
        mem_req.we      = 1'b1;
        mem_req.addr    = cell_addr(mid_x, mid_y);
        mem_req.wdata   = CELL_PASS;
        walk_col_next   = tgt_x;
        walk_row_next   = tgt_y;
        res_carved_next = 1'b1;
        state_next      = ST_RESULT;
      end

      ST_BT_ISSUE: begin
        mem_req.addr = cell_addr(walk_col, walk_row);
        state_next   = ST_BT_EVAL;
      end

      // One backtrack step per read
      ST_BT_EVAL: begin
        if (dir_bits != '0) begin
          state_next = ST_RESULT;
        end else if ((walk_col == START_POS) && (walk_row == START_POS)) begin
          finished_next = 1'b1;
          state_next    = ST_RESULT;
        end else begin
          unique case (dir_t'(mem_rdata[PDIR_SHIFT +: DIR_W]))
            DIR_RIGHT: bx = walk_col - COORD_W'(2);
            DIR_DOWN:  by = walk_row - COORD_W'(2);
            DIR_LEFT:  bx = walk_col + COORD_W'(2);
            default:   by = walk_row + COORD_W'(2);
          endcase
          walk_col_next = bx;
          walk_row_next = by;
          if ((bx == START_POS) && (by == START_POS)) begin
            finished_next = 1'b1;
            state_next    = ST_RESULT;
          end else begin
            state_next = ST_BT_ISSUE;
          end
        end
      end

      ST_READ_EVAL: begin
        res_open_next = mem_rdata[OPEN_IDX];
        state_next    = ST_RESULT;
      end

      ST_RESULT: begin
        if (res_take) begin
          state_next = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      walk_col    <= START_POS;
      walk_row    <= START_POS;
      finished    <= 1'b1;
      store_valid <= 1'b0;
      grid_w      <= SIZE_RST;
      grid_h      <= SIZE_RST;
      res_open    <= 1'b0;
      res_carved  <= 1'b0;
      res_bad     <= 1'b0;
    end else begin
      state       <= state_next;
      walk_col    <= walk_col_next;
      walk_row    <= walk_row_next;
      finished    <= finished_next;
      store_valid <= store_valid_next;
      grid_w      <= grid_w_next;
      grid_h      <= grid_h_next;
      res_open    <= res_open_next;
      res_carved  <= res_carved_next;
      res_bad     <= res_bad_next;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    dir     <= dir_next;
    tgt_x   <= tgt_x_next;
    tgt_y   <= tgt_y_next;
    sweep_x <= sweep_x_next;
    sweep_y <= sweep_y_next;
  end

  // Size registers, used at the next start
  always_ff @(posedge clk) begin
    if (rst) begin
      maze_width  <= SIZE_RST;
      maze_height <= SIZE_RST;
    end else if (cfg.valid) begin
      if (cfg.index == REG_MAZE_WIDTH) begin
        maze_width <= cfg.data;
      end else begin
        maze_height <= cfg.data;
      end
    end
  end

  `AST_IMPL(a_we_state, clk, rst, mem_req.we |-> (state == ST_SWEEP || state == ST_HERE_EVAL || state == ST_TGT_EVAL || state == ST_MID_WR), "store written outside a write state")
  `AST_NEVER(a_walk_odd, clk, rst, !(walk_col[0] && walk_row[0]), "walk left the odd node grid")
  `AST_IMPL(a_carve_live, clk, rst, (state == ST_RESULT && res_carved) |-> !finished, "carve reported on a finished maze")
  `AST_IMPL(a_sweep_end, clk, rst, (state == ST_SWEEP && sweep_last) |=> (state == ST_RESULT), "sweep did not end at last cell")

endmodule

@@ design/random_dfs_maze_carver.sv @@
// Maze carver top level: sequencer, cell store and result register.
//
// Channels: req carries start (0), draw (1) and read (2) transactions; rsp returns exactly
// one result transaction per request; cfg writes maze_width (index 0) and maze_height
// (index 1), which take effect at the next start.
// start writes all 4096 cells of the cell store, one cell store write per cycle; a refused
// start goes straight to the result register. draw may carve a passage or backtrack toward
// (1,1), one step per read, and goes straight to the result once generation is done. read
// goes straight to the result outside the grid.
// One request is in work at a time; the single read/write port of the cell store sets the
// pace, with each access of a read-modify-write in its own state.
// Reset needs no pass over the store: until the first start, reads return wall. The
// finished flag is set and the walk sits at (1,1).
// The result waits in an output register; the next request is accepted while it waits,
// and only its own result stalls until the receiver takes the earlier one.
module random_dfs_maze_carver (
  input logic      clk,
  input logic      rst,
  rdmc_req_if.sink req,
  rdmc_rsp_if.source rsp,
  rdmc_cfg_if.sink cfg
);
  import rdmc_pkg::*;

  rsp_t     res;
  logic     res_valid;
  logic     res_take;
  rsp_t     out_data;
  logic     out_valid;
  mem_req_t mem_req;
  logic [CELL_W-1:0] mem_rdata;

  rdmc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg       (cfg),
    .res       (res),
    .res_valid (res_valid),
    .res_take  (res_take),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  rdmc_ram #(
    .WIDTH (CELL_W),
    .DEPTH (STORE_SIZE)
  ) u_store (
    .clk   (clk),
    .we    (mem_req.we),
    .addr  (mem_req.addr),
    .wdata (mem_req.wdata),
    .rdata (mem_rdata)
  );

  // Result register: loads when empty or being drained
  assign res_take = res_valid && (!out_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data <= res;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.cell_open = out_data.cell_open;
  assign rsp.gen_done  = out_data.gen_done;
  assign rsp.carved    = out_data.carved;
  assign rsp.walk_x    = out_data.walk_x;
  assign rsp.walk_y    = out_data.walk_y;
  assign rsp.bad_size  = out_data.bad_size;

endmodule
